@@ rtl/jsed_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsed_pkg
// Shared types and constants for the escape decoder: beat structs, the
// parser mode encoding and the decoded-byte group passed front to back.
// ----------------------------------------------------------------------------
package jsed_pkg;

  // Most decoded bytes one input byte can settle.
  localparam int MaxRes = 5;
  localparam int GrpCntW = $clog2(MaxRes + 1);

  // Default depth of the group queue between front and back.
  localparam int GrpQDepth = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_end;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
  } out_beat_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_BSL  = 3'd1,
    MODE_U    = 3'd2,
    MODE_X    = 3'd3,
    MODE_OCT  = 3'd4
  } mode_t;

  // Bytes decoded from one input beat, oldest in slot 0.
  typedef struct packed {
    logic [GrpCntW-1:0]      cnt;
    logic                    str_end;
    logic [MaxRes-1:0][7:0]  bytes;
  } grp_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic empty;
    grp_t grp;
  } grp_head_t;

endpackage

@@ rtl/js_escape_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// js_escape_decoder_core
// JavaScript string escape decoder: raw escaped bytes in, decoded bytes out.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload     | beat
//  --------+--------------------+-------------+-------------------------------
//  item    | push / full        | in_beat_t   | one raw byte + end-of-string
//  result  | empty / pop        | out_beat_t  | one decoded byte + markers
//
//  One raw byte is taken per cycle while the group queue has room.
//  Results leave at one beat per cycle while they are popped, so a byte that
//  settles several decoded bytes keeps the serializer busy for each of them in turn; the group queue soaks that up.
//  With the serializer free, the first result of a byte goes from the group
//  queue, written when that byte is taken, into the result register, which
//  then drives it on the ports.
//  Synchronous reset returns the parser to idle and empties queue and output.
//  A stalled result stays until popped; the parser runs until the queue fills.
//
// Structure:
//  - jsed_front: escape parser state (mode, up to three held digits). Each
//    byte yields a group of 0..5 decoded bytes, built in the same cycle.
//    Bytes that settle nothing write no group.
//  - jsed_grp_q: small group queue; its full flag is the block's full.
//  - jsed_back: steps through the head group, one byte into the result
//    register per cycle unless a result waits unpopped; run_last marks the
//    last byte of a group, string_done that of a group ending the string.
//
module js_escape_decoder_core #(
  parameter int GrpDepth = jsed_pkg::GrpQDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  jsed_pkg::in_beat_t  item,
  output logic                empty,
  input  logic                pop,
  output jsed_pkg::out_beat_t result
);
  import jsed_pkg::*;

  logic      grp_wr;
  grp_t      grp;
  logic      q_rd;
  grp_head_t head;

  // parser
  jsed_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .q_full (full),
    .item   (item),
    .grp_wr (grp_wr),
    .grp    (grp)
  );

  // front/back decoupling queue
  jsed_grp_q #(
    .Depth (GrpDepth)
  ) u_grp_q (
    .clk    (clk),
    .rst    (rst),
    .wr     (grp_wr),
    .wr_grp (grp),
    .full   (full),
    .rd     (q_rd),
    .head   (head)
  );

  // serializer and result register
  jsed_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_rd   (q_rd),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

@@ rtl/jsed_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsed_front
// Escape parser. Takes one raw byte per cycle while the queue has room,
// updates the escape state and produces the group of decoded bytes it settles.
// ----------------------------------------------------------------------------
module jsed_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             q_full,
  input  jsed_pkg::in_beat_t item,
  output logic             grp_wr,
  output jsed_pkg::grp_t   grp
);
  import jsed_pkg::*;

  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_3   = 8'h33;
  localparam logic [7:0] CH_7   = 8'h37;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_UA  = 8'h41;
  localparam logic [7:0] CH_UF  = 8'h46;
  localparam logic [7:0] CH_LA  = 8'h61;
  localparam logic [7:0] CH_LB  = 8'h62;
  localparam logic [7:0] CH_LF  = 8'h66;
  localparam logic [7:0] CH_LN  = 8'h6E;
  localparam logic [7:0] CH_LR  = 8'h72;
  localparam logic [7:0] CH_LT  = 8'h74;
  localparam logic [7:0] CH_LU  = 8'h75;
  localparam logic [7:0] CH_LV  = 8'h76;
  localparam logic [7:0] CH_LX  = 8'h78;
  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] FW_LIM = 8'h5F;
  localparam logic [7:0] FW_ADD = 8'h20;

  function automatic logic is_hex(logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF) ||
           (c >= CH_UA && c <= CH_UF);
  endfunction

  function automatic logic is_oct(logic [7:0] c);
    return c >= CH_0 && c <= CH_7;
  endfunction

  function automatic logic is_f(logic [7:0] c);
    return c == CH_LF || c == CH_UF;
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] v;
    if (c >= CH_LA) v = c - CH_LA + 8'd10;
    else if (c >= CH_UA) v = c - CH_UA + 8'd10;
    else v = c - CH_0;
    return v[3:0];
  endfunction

  function automatic logic [7:0] esc_map(logic [7:0] c);
    logic [7:0] o;
    case (c)
      CH_LA:   o = 8'h07;
      CH_LB:   o = 8'h08;
      CH_LF:   o = 8'h0C;
      CH_LN:   o = 8'h0A;
      CH_LR:   o = 8'h0D;
      CH_LT:   o = 8'h09;
      CH_LV:   o = 8'h0B;
      default: o = c;
    endcase
    return o;
  endfunction

  function automatic logic [7:0] oct_val(logic [23:0] h, logic [1:0] n);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = h[15:8] - CH_0;
    lo = h[7:0] - CH_0;
    if (n >= 2'd2) return (hi << 3) + lo;
    return lo;
  endfunction

  function automatic grp_t grp_push(grp_t g, logic [7:0] b);
    grp_t r;
    r = g;
    if (g.cnt < GrpCntW'(MaxRes)) begin
      r.bytes[g.cnt] = b;
      r.cnt = g.cnt + 1'b1;
    end
    return r;
  endfunction

  // Letter of a broken \u or \x, then its held digits oldest first.
  function automatic grp_t grp_flush(grp_t g, logic [7:0] letter, logic [23:0] h,
                                     logic [1:0] n);
    grp_t r;
    r = grp_push(g, letter);
    if (n >= 2'd3) r = grp_push(r, h[23:16]);
    if (n >= 2'd2) r = grp_push(r, h[15:8]);
    if (n >= 2'd1) r = grp_push(r, h[7:0]);
    return r;
  endfunction

  mode_t       mode, mode_next;
  logic [23:0] held, held_next;
  logic [1:0]  hcnt, hcnt_next;
  logic        accept;
  logic        redo;
  logic [7:0]  c;
  logic [7:0]  lo;
  logic [7:0]  d2, d1, d0;

  assign accept = push && !q_full;
  assign c      = item.in_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      held <= '0;
      hcnt <= '0;
    end else if (accept) begin
      mode <= mode_next;
      held <= held_next;
      hcnt <= hcnt_next;
    end
  end

  always_comb begin
    mode_next = mode;
    held_next = held;
    hcnt_next = hcnt;
    redo      = 1'b0;
    grp       = '0;
    lo        = {hex_val(held[7:0]), hex_val(c)};
    d2        = held[15:8] - CH_0;
    d1        = held[7:0] - CH_0;
    d0        = c - CH_0;

    case (mode)
      MODE_BSL: begin
        if (c == CH_LU) begin
          mode_next = MODE_U;
        end else if (c == CH_LX) begin
          mode_next = MODE_X;
        end else if (is_oct(c)) begin
          mode_next = MODE_OCT;
          held_next = {held[15:0], c};
          hcnt_next = hcnt + 2'd1;
        end else begin
          grp       = grp_push(grp, esc_map(c));
          mode_next = MODE_IDLE;
          held_next = '0;
          hcnt_next = '0;
        end
      end
      MODE_U: begin
        if (!is_hex(c)) begin
          grp  = grp_flush(grp, CH_LU, held, hcnt);
          redo = 1'b1;
        end else if (hcnt < 2'd3) begin
          held_next = {held[15:0], c};
          hcnt_next = hcnt + 2'd1;
        end else begin
          // full-width ASCII: \uFFxx folds back into the printable range
          if (lo != 8'h00 && lo < FW_LIM && is_f(held[23:16]) && is_f(held[15:8]))
            lo = lo + FW_ADD;
          grp       = grp_push(grp, lo);
          mode_next = MODE_IDLE;
          held_next = '0;
          hcnt_next = '0;
        end
      end
      MODE_X: begin
        if (!is_hex(c)) begin
          grp  = grp_flush(grp, CH_LX, held, hcnt);
          redo = 1'b1;
        end else if (hcnt < 2'd1) begin
          held_next = {held[15:0], c};
          hcnt_next = hcnt + 2'd1;
        end else begin
          grp       = grp_push(grp, lo);
          mode_next = MODE_IDLE;
          held_next = '0;
          hcnt_next = '0;
        end
      end
      MODE_OCT: begin
        if (!is_oct(c)) begin
          grp  = grp_push(grp, oct_val(held, hcnt));
          redo = 1'b1;
        end else if (hcnt < 2'd2) begin
          held_next = {held[15:0], c};
          hcnt_next = hcnt + 2'd1;
        end else begin
          if (held[15:8] <= CH_3) begin
            grp = grp_push(grp, (d2 << 6) + (d1 << 3) + d0);
          end else begin
            // leading digit too big for three: third digit goes out as is
            grp = grp_push(grp, oct_val(held, hcnt));
            grp = grp_push(grp, c);
          end
          mode_next = MODE_IDLE;
          held_next = '0;
          hcnt_next = '0;
        end
      end
      default: begin
        redo = 1'b1;
      end
    endcase

    // Byte handled afresh from idle.
    if (redo) begin
      held_next = '0;
      hcnt_next = '0;
      if (c == CH_BSL) begin
        mode_next = MODE_BSL;
      end else begin
        mode_next = MODE_IDLE;
        grp       = grp_push(grp, c);
      end
    end

    // End of string: flush whatever escape is still open.
    if (item.in_end) begin
      case (mode_next)
        MODE_BSL: grp = grp_push(grp, CH_BSL);
        MODE_U:   grp = grp_flush(grp, CH_LU, held_next, hcnt_next);
        MODE_X:   grp = grp_flush(grp, CH_LX, held_next, hcnt_next);
        MODE_OCT: grp = grp_push(grp, oct_val(held_next, hcnt_next));
        default:  grp = grp;
      endcase
      mode_next = MODE_IDLE;
      held_next = '0;
      hcnt_next = '0;
    end
    grp.str_end = item.in_end;
  end

  assign grp_wr = accept && (grp.cnt != '0);

endmodule

@@ rtl/jsed_grp_q.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsed_grp_q
// Short queue of decoded-byte groups between parser and serializer.
// ----------------------------------------------------------------------------
module jsed_grp_q #(
  parameter int Depth = jsed_pkg::GrpQDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  jsed_pkg::grp_t      wr_grp,
  output logic                full,
  input  logic                rd,
  output jsed_pkg::grp_head_t head
);
  import jsed_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  grp_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr, do_rd;

  assign full       = count == CntW'(Depth);
  assign head.empty = count == '0;
  assign head.grp   = mem[rd_ptr];
  assign do_wr      = wr && !full;
  assign do_rd      = rd && !head.empty;

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_grp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/jsed_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsed_back
// Serializer. Walks the head group into a registered result beat, one byte
// per cycle while no result waits, marking the last byte of group and string.
// ----------------------------------------------------------------------------
module jsed_back (
  input  logic                 clk,
  input  logic                 rst,
  input  jsed_pkg::grp_head_t  head,
  output logic                 q_rd,
  output logic                 empty,
  input  logic                 pop,
  output jsed_pkg::out_beat_t  result
);
  import jsed_pkg::*;

  logic [GrpCntW-1:0] idx;
  logic               out_valid;
  logic               load;
  logic               last;

  assign load  = !out_valid || pop;
  assign last  = idx == (head.grp.cnt - 1'b1);
  assign q_rd  = load && !head.empty && last;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= !head.empty;
      if (!head.empty) idx <= last ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !head.empty) begin
      result.out_byte    <= head.grp.bytes[idx];
      result.run_last    <= last;
      result.string_done <= last && head.grp.str_end;
    end
  end

endmodule

@@ rtl/jsed_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsed_checker
// Port-level checks for the escape decoder, bound onto the top level.
// ----------------------------------------------------------------------------
module jsed_checker (
  input logic                clk,
  input logic                rst,
  input logic                push,
  input logic                full,
  input jsed_pkg::in_beat_t  item,
  input logic                empty,
  input logic                pop,
  input jsed_pkg::out_beat_t result
);

  // string end always closes a group
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    !empty && result.string_done |-> result.run_last)
    else $error("string_done without run_last");

  // reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  // reset leaves the queue with room
  a_rst_room: assert property (@(posedge clk) rst |=> !full)
    else $error("full after reset");

  // a result waiting for pop stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("stalled result changed");

  // an accepted item beat carries known bits
  a_item_known: assert property (@(posedge clk) disable iff (rst)
    push && !full |-> !$isunknown(item))
    else $error("unknown item accepted");

endmodule

bind js_escape_decoder_core jsed_checker u_chk (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .item   (item),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
